/* design/lpft_pkg.sv */
// ----------------------------------------------------------------------------
// lpft_pkg
// Shared constants for the LRU page frame tracker: the widths of the
// frame-limit register and the fault counter, and the limit after reset.
// ----------------------------------------------------------------------------
package lpft_pkg;

  // frame-limit register
  localparam int unsigned CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // running fault total
  localparam int unsigned FAULT_W = 32;
  localparam logic [FAULT_W-1:0] FAULT_MAX = {FAULT_W{1'b1}};

endpackage : lpft_pkg

/* design/lru_page_frame_tracker.sv */
// ----------------------------------------------------------------------------
// lru_page_frame_tracker
// Fully associative page frame table with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive process_id and page_number with start high; the request is
//   taken at a rising edge where start is high and busy is low. busy is high
//   only during reset, so a new request may be issued in every cycle.
//   Result: done pulses for one cycle with page_fault, evicted,
//   evicted_process, evicted_page and fault_total. The receiver cannot stall
//   the block; each result must be taken in the cycle it is shown.
//   An accepted request is held in the request register, then the result
//   register; one request per cycle is taken. The request register feeds a
//   single pass in which the page is compared against every frame at once,
//   the victim is the valid frame whose rank equals the occupancy less one,
//   and all ranks are updated together before the result register.
//   Configuration: frames_in_use is written when frames_in_use_we is high;
//   the user must do so only while no request is in flight, which the block
//   does not enforce. 0 acts as 1, above FRAMES as FRAMES.
//   Reset (rst, synchronous): all frames free, fault total zero, limit 16.
// ----------------------------------------------------------------------------
module lru_page_frame_tracker
  import lpft_pkg::*;
#(
  parameter int unsigned FRAMES       = 16,
  parameter int unsigned PAGE_BITS    = 20,
  parameter int unsigned PROCESS_BITS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  // request channel
  input  logic                    start,
  output logic                    busy,
  input  logic [PROCESS_BITS-1:0] process_id,
  input  logic [PAGE_BITS-1:0]    page_number,
  // frame-limit register
  input  logic                    frames_in_use_we,
  input  logic [CFG_W-1:0]        frames_in_use,
  // result channel
  output logic                    done,
  output logic                    page_fault,
  output logic                    evicted,
  output logic [PROCESS_BITS-1:0] evicted_process,
  output logic [PAGE_BITS-1:0]    evicted_page,
  output logic [FAULT_W-1:0]      fault_total
);

  localparam int unsigned RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned OCC_W  = $clog2(FRAMES + 1);
  localparam int unsigned CMP_W  = (OCC_W > CFG_W) ? OCC_W : CFG_W;

  typedef logic [RANK_W-1:0] rank_t;

  // frame table
  logic [PROCESS_BITS-1:0] frame_process [FRAMES];
  logic [PAGE_BITS-1:0]    frame_page    [FRAMES];
  logic [FRAMES-1:0]       frame_valid;
  rank_t                   frame_recency [FRAMES];
  logic [OCC_W-1:0]        frames_occupied;
  logic [FAULT_W-1:0]      fault_counter;
  logic [CFG_W-1:0]        frames_limit;

  // request register
  logic                    req_valid;
  logic [PROCESS_BITS-1:0] req_proc;
  logic [PAGE_BITS-1:0]    req_page;

  // single-pass lookup and update
  logic [FRAMES-1:0]       hit_vec;
  logic                    hit;
  rank_t                   hit_rank;
  logic [CMP_W-1:0]        limit_eff;
  logic                    evict;
  rank_t                   victim_rank;
  logic [FRAMES-1:0]       victim_vec;
  logic [FRAMES-1:0]       free_vec;
  logic [FRAMES-1:0]       free_first;
  logic [FRAMES-1:0]       load_vec;
  logic                    load;
  logic [PROCESS_BITS-1:0] ev_proc;
  logic [PAGE_BITS-1:0]    ev_page;
  logic [FRAMES-1:0]       frame_valid_next;
  rank_t                   frame_recency_next [FRAMES];
  logic [OCC_W-1:0]        frames_occupied_next;
  logic [FAULT_W-1:0]      fault_counter_next;

  // no request is taken while in reset
  assign busy = rst;

  // match against every frame
  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < FRAMES; i++) begin
      hit_vec[i] = frame_valid[i] && (frame_process[i] == req_proc) &&
                   (frame_page[i] == req_page);
      if (hit_vec[i]) hit_rank |= frame_recency[i];
    end
    hit = |hit_vec;
  end

  // clamp the limit to 1 .. FRAMES
  always_comb begin
    if (frames_limit == '0) begin
      limit_eff = CMP_W'(1);
    end else if (CMP_W'(frames_limit) > CMP_W'(FRAMES)) begin
      limit_eff = CMP_W'(FRAMES);
    end else begin
      limit_eff = CMP_W'(frames_limit);
    end
  end

  // victim: ranks are distinct 0 .. occupied-1, so the oldest is occupied-1
  assign evict       = !hit && (CMP_W'(frames_occupied) >= limit_eff);
  assign victim_rank = RANK_W'(frames_occupied - OCC_W'(1));

  always_comb begin
    ev_proc = '0;
    ev_page = '0;
    for (int i = 0; i < FRAMES; i++) begin
      victim_vec[i] = evict && frame_valid[i] && (frame_recency[i] == victim_rank);
      if (victim_vec[i]) begin
        ev_proc |= frame_process[i];
        ev_page |= frame_page[i];
      end
    end
  end

  // lowest-numbered free frame for a fill
  assign free_vec   = ~frame_valid;
  assign free_first = free_vec & (~free_vec + FRAMES'(1));
  assign load_vec   = hit ? '0 : (evict ? victim_vec : free_first);
  assign load       = |load_vec;

  // next ranks, valid bits and counts
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      frame_valid_next[i]   = frame_valid[i] | load_vec[i];
      frame_recency_next[i] = frame_recency[i];
      if (hit) begin
        if (hit_vec[i]) begin
          frame_recency_next[i] = '0;
        end else if (frame_valid[i] && (frame_recency[i] < hit_rank)) begin
          frame_recency_next[i] = frame_recency[i] + rank_t'(1);
        end
      end else if (load) begin
        if (load_vec[i]) begin
          frame_recency_next[i] = '0;
        end else if (frame_valid[i]) begin
          frame_recency_next[i] = frame_recency[i] + rank_t'(1);
        end
      end
    end
    frames_occupied_next = frames_occupied;
    if (load && !evict) frames_occupied_next = frames_occupied + OCC_W'(1);
    fault_counter_next = fault_counter;
    if (!hit && (fault_counter != FAULT_MAX)) begin
      fault_counter_next = fault_counter + FAULT_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid     <= '0;
      frames_occupied <= '0;
      fault_counter   <= '0;
      frames_limit    <= CFG_RESET;
      req_valid       <= 1'b0;
      done            <= 1'b0;
      for (int i = 0; i < FRAMES; i++) frame_recency[i] <= '0;
    end else begin
      if (frames_in_use_we) frames_limit <= frames_in_use;
      req_valid <= start && !busy;
      done      <= req_valid;
      if (req_valid) begin
        frame_valid     <= frame_valid_next;
        frames_occupied <= frames_occupied_next;
        fault_counter   <= fault_counter_next;
        for (int i = 0; i < FRAMES; i++) frame_recency[i] <= frame_recency_next[i];
      end
    end
  end

  // payload: request, frame contents, result
  always_ff @(posedge clk) begin
    req_proc <= process_id;
    req_page <= page_number;
    if (req_valid) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (load_vec[i]) begin
          frame_process[i] <= req_proc;
          frame_page[i]    <= req_page;
        end
      end
      page_fault      <= !hit;
      evicted         <= evict;
      evicted_process <= ev_proc;
      evicted_page    <= ev_page;
      fault_total     <= fault_counter_next;
    end
  end

endmodule : lru_page_frame_tracker

/* dv/lru_page_frame_tracker_tb.sv */
// ----------------------------------------------------------------------------
// lru_page_frame_tracker_tb
// Self-checking bench for the LRU page frame tracker. Page references are
// driven in random bursts while a behavioural frame table predicts the
// hit/fault flag, any eviction and the running fault total. Each done pulse
// is checked against the oldest prediction. The frame limit is changed
// between phases, including out-of-range values and lowering while full.
// ----------------------------------------------------------------------------
module lru_page_frame_tracker_tb
  import lpft_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAME_N = 16;
  localparam int unsigned PROC_W  = 8;
  localparam int unsigned PAGE_W  = 20;
  localparam int unsigned LATENCY = 2;
  localparam int unsigned POOL_N  = 32;

  typedef struct packed {
    logic               page_fault;
    logic               evicted;
    logic [PROC_W-1:0]  evicted_process;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_total;
  } page_result_t;

  // DUT connections
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [PROC_W-1:0]  process_id = '0;
  logic [PAGE_W-1:0]  page_number = '0;
  logic               frames_in_use_we = 1'b0;
  logic [CFG_W-1:0]   frames_in_use = '0;
  logic               done;
  logic               page_fault;
  logic               evicted;
  logic [PROC_W-1:0]  evicted_process;
  logic [PAGE_W-1:0]  evicted_page;
  logic [FAULT_W-1:0] fault_total;

  // predicted frame table
  logic [PROC_W-1:0]  tbl_proc [FRAME_N];
  logic [PAGE_W-1:0]  tbl_page [FRAME_N];
  logic               tbl_valid [FRAME_N];
  int unsigned        tbl_rank [FRAME_N];
  int unsigned        tbl_occupied;
  logic [FAULT_W-1:0] fault_count;
  logic [CFG_W-1:0]   frame_limit;

  page_result_t       pending_results [$];
  int unsigned        mismatches;
  int unsigned        burst_left;

  // reference working set
  logic [PROC_W-1:0]  ws_proc [POOL_N];
  logic [PAGE_W-1:0]  ws_page [POOL_N];

  lru_page_frame_tracker u_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .process_id       (process_id),
    .page_number      (page_number),
    .frames_in_use_we (frames_in_use_we),
    .frames_in_use    (frames_in_use),
    .done             (done),
    .page_fault       (page_fault),
    .evicted          (evicted),
    .evicted_process  (evicted_process),
    .evicted_page     (evicted_page),
    .fault_total      (fault_total)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Frame table prediction
  // --------------------------------------------------------------------------
  function automatic void clear_table();
    for (int i = 0; i < FRAME_N; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_rank[i]  = 0;
      tbl_proc[i]  = '0;
      tbl_page[i]  = '0;
    end
    tbl_occupied = 0;
    fault_count  = '0;
    frame_limit  = CFG_RESET;
  endfunction

  function automatic page_result_t lookup_page(input logic [PROC_W-1:0] proc,
                                               input logic [PAGE_W-1:0] page);
    page_result_t res;
    int           hit_idx;
    int           slot;
    int unsigned  limit_eff;
    int unsigned  worst;
    int unsigned  hit_rank;
    res     = '0;
    hit_idx = -1;
    slot    = -1;
    worst   = 0;
    for (int i = 0; i < FRAME_N; i++) begin
      if (tbl_valid[i] && tbl_proc[i] == proc && tbl_page[i] == page) hit_idx = i;
    end
    if (hit_idx >= 0) begin
      // hit: frames more recent than this one age by one
      hit_rank = tbl_rank[hit_idx];
      for (int i = 0; i < FRAME_N; i++) begin
        if (tbl_valid[i] && tbl_rank[i] < hit_rank) tbl_rank[i]++;
      end
      tbl_rank[hit_idx] = 0;
    end else begin
      res.page_fault = 1'b1;
      if (fault_count != FAULT_MAX) fault_count++;
      limit_eff = (frame_limit == 0) ? 1 :
                  (frame_limit > FRAME_N) ? FRAME_N : frame_limit;
      // at or over the limit: evict the least recent frame
      if (tbl_occupied >= limit_eff) begin
        for (int i = 0; i < FRAME_N; i++) begin
          if (tbl_valid[i] && (slot < 0 || tbl_rank[i] > worst)) begin
            slot  = i;
            worst = tbl_rank[i];
          end
        end
        if (slot >= 0) begin
          res.evicted         = 1'b1;
          res.evicted_process = tbl_proc[slot];
          res.evicted_page    = tbl_page[slot];
          tbl_valid[slot]     = 1'b0;
          tbl_occupied--;
        end
      end
      // otherwise the lowest free frame
      for (int i = 0; i < FRAME_N; i++) begin
        if (slot < 0 && !tbl_valid[i]) slot = i;
      end
      if (slot >= 0) begin
        for (int i = 0; i < FRAME_N; i++) begin
          if (tbl_valid[i]) tbl_rank[i]++;
        end
        tbl_valid[slot] = 1'b1;
        tbl_proc[slot]  = proc;
        tbl_page[slot]  = page;
        tbl_rank[slot]  = 0;
        tbl_occupied++;
      end
    end
    res.fault_total = fault_count;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request driving (called at a falling edge, returns at a falling edge)
  // --------------------------------------------------------------------------
  task automatic send_ref(input logic [PROC_W-1:0] proc, input logic [PAGE_W-1:0] page);
    int unsigned gap;
    // bursts with random gaps; some bursts run back to back
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    start       <= 1'b1;
    process_id  <= proc;
    page_number <= page;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_results = {pending_results, lookup_page(proc, page)};
    @(negedge clk);
  endtask

  task automatic send_random_ref();
    send_ref(PROC_W'($urandom), PAGE_W'($urandom));
  endtask

  // limit write, only once the pipe has drained
  task automatic set_limit(input logic [CFG_W-1:0] value);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 1) @(negedge clk);
    frames_in_use_we <= 1'b1;
    frames_in_use    <= value;
    @(negedge clk);
    frames_in_use_we <= 1'b0;
    frame_limit = value;
    burst_left  = 0;
  endtask

  // fresh working set; some entries share a process or a page with another
  task automatic build_working_set();
    int unsigned other;
    for (int i = 0; i < POOL_N; i++) begin
      ws_proc[i] = PROC_W'($urandom);
      ws_page[i] = PAGE_W'($urandom);
      if (i > 0 && $urandom_range(0, 4) == 0) begin
        other = $urandom_range(0, i - 1);
        if ($urandom_range(0, 1) == 0) ws_proc[i] = ws_proc[other];
        else ws_page[i] = ws_page[other];
      end
    end
  endtask

  // mostly working-set references, some noise
  task automatic run_refs(input int unsigned count, input int unsigned ws_size);
    int unsigned k;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 85) begin
        k = $urandom_range(0, ws_size - 1);
        send_ref(ws_proc[k], ws_page[k]);
      end else begin
        send_random_ref();
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    page_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: result with no request pending", $realtime);
      end else begin
        exp_r = pending_results.pop_front();
        check_field("page_fault", 32'(exp_r.page_fault), 32'(page_fault));
        check_field("evicted", 32'(exp_r.evicted), 32'(evicted));
        check_field("evicted_process", 32'(exp_r.evicted_process), 32'(evicted_process));
        check_field("evicted_page", 32'(exp_r.evicted_page), 32'(evicted_page));
        check_field("fault_total", exp_r.fault_total, fault_total);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // field extremes, partial matches, fill to full, evict, hit on LRU
  task automatic test_directed();
    send_ref('0, '0);
    send_ref('1, '1);
    send_ref('0, '0);
    send_ref('1, '0);
    send_ref('0, '1);
    send_ref('1, '1);
    for (int i = 0; i < 12; i++) send_ref(PROC_W'(i + 1), PAGE_W'(20'h55555 ^ i));
    send_ref(8'haa, 20'haaaaa);
    send_ref('1, '0);
    send_ref(8'haa, 20'haaaaa);
    send_ref(8'h0c, 20'h55559);
    send_ref('0, '0);
    send_ref(8'h01, 20'h55555);
  endtask

  // out-of-range limits and lowering the limit while the table is full
  task automatic test_limits();
    set_limit(5'd1);
    build_working_set();
    run_refs(30, 3);
    set_limit(5'd0);
    run_refs(30, 3);
    set_limit(5'd31);
    build_working_set();
    run_refs(60, 20);
    set_limit(5'd17);
    run_refs(30, 20);
    set_limit(5'd16);
    for (int i = 0; i < FRAME_N; i++) send_random_ref();
    set_limit(5'd3);
    build_working_set();
    run_refs(40, 6);
    set_limit(5'd2);
    run_refs(30, 4);
  endtask

  // long random phases over a spread of limits
  task automatic test_random();
    logic [CFG_W-1:0] limits [8] = '{5'd16, 5'd5, 5'd1, 5'd0, 5'd31, 5'd9, 5'd2, 5'd14};
    int unsigned      eff;
    int unsigned      ws_size;
    foreach (limits[p]) begin
      set_limit(limits[p]);
      eff = (limits[p] == 0) ? 1 : (limits[p] > FRAME_N) ? FRAME_N : limits[p];
      ws_size = eff + $urandom_range(1, 5);
      build_working_set();
      run_refs(85, ws_size);
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    mismatches = 0;
    burst_left = 0;
    clear_table();
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);
    test_directed();
    test_limits();
    test_random();
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule : lru_page_frame_tracker_tb
